// ----- rtl/core/slot_bitmap_allocator_assert.svh -----
// ---------------------------------------------------------------------------
// slot bitmap allocator assertion macros
// shared property wrappers, clocked on clk and disabled in rst
// ---------------------------------------------------------------------------
`ifndef SLOT_BITMAP_ALLOCATOR_ASSERT_SVH
`define SLOT_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sba_pkg.sv -----
// ---------------------------------------------------------------------------
// sba_pkg
// shared constants, types and helpers of the slot bitmap allocator
// ---------------------------------------------------------------------------
package sba_pkg;

  localparam int WORD_COUNT    = 8;
  localparam int BITS_PER_WORD = 32;
  localparam int TOTAL_SLOTS   = WORD_COUNT * BITS_PER_WORD;

  localparam int SLOT_W = 8;
  localparam int CNT_W  = 9;
  localparam int BIT_W  = $clog2(BITS_PER_WORD);
  localparam int WIDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int SUM_RAW_W = $clog2(TOTAL_SLOTS + BITS_PER_WORD + 1);
  localparam int SUM_W  = (SUM_RAW_W > SLOT_W) ? SUM_RAW_W : SLOT_W + 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_TEST  = 2'd2,
    FUNC_FIND  = 2'd3
  } func_t;

  typedef struct packed {
    logic start;
    logic step;
    logic publish;
  } sba_cmd_t;

  typedef struct packed {
    logic done;
  } sba_sts_t;

  // index of the lowest set bit, zero when none
  function automatic logic [BIT_W-1:0] first_one(input logic [BITS_PER_WORD-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/sba_req_if.sv -----
// ---------------------------------------------------------------------------
// sba_req_if
// request channel: valid/ready with request code and slot index
// ---------------------------------------------------------------------------
interface sba_req_if import sba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, output func, output slot_index, input ready);
  modport sink   (input valid, input func, input slot_index, output ready);
endinterface

// ----- rtl/core/sba_rsp_if.sv -----
// ---------------------------------------------------------------------------
// sba_rsp_if
// response channel: valid/ready with status, index, test bit and count
// ---------------------------------------------------------------------------
interface sba_rsp_if import sba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [SLOT_W-1:0] result_index;
  logic              slot_set;
  logic [CNT_W-1:0]  used_count;

  modport source (output valid, output status, output result_index, output slot_set,
                  output used_count, input ready);
  modport sink   (input valid, input status, input result_index, input slot_set,
                  input used_count, output ready);
endinterface

// ----- rtl/core/sba_ctrl.sv -----
// ---------------------------------------------------------------------------
// sba_ctrl
// request sequencer: accept, word scan, hand result to the output register
// ---------------------------------------------------------------------------
module sba_ctrl import sba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output sba_cmd_t cmd,
  input  sba_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POST
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free    = !out_valid || out_ready;
  assign cmd.start   = in_valid && in_ready;
  assign cmd.step    = (state == ST_SCAN);
  assign cmd.publish = (state == ST_POST) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_SCAN;
            in_ready <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (sts.done) state <= ST_POST;
        end
        ST_POST: begin
          if (out_free) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b1;
        end
      endcase

      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/sba_datapath.sv -----
// ---------------------------------------------------------------------------
// sba_datapath
// occupancy bitmap, slot count and one-word-per-cycle scan logic
// ---------------------------------------------------------------------------
`include "slot_bitmap_allocator_assert.svh"

module sba_datapath import sba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  sba_cmd_t          cmd,
  output sba_sts_t          sts,
  input  logic [1:0]        in_func,
  input  logic [SLOT_W-1:0] in_slot,
  output logic              out_status,
  output logic [SLOT_W-1:0] out_index,
  output logic              out_set,
  output logic [CNT_W-1:0]  out_count
);

  logic [BITS_PER_WORD-1:0] bitmap [WORD_COUNT];
  logic [CNT_W-1:0]         count;
  logic [WIDX_W-1:0]        w;
  logic [SUM_W-1:0]         base;
  func_t                    func_r;
  logic [SLOT_W-1:0]        slot_r;
  logic                     res_status;
  logic [SLOT_W-1:0]        res_index;
  logic                     res_set;

  logic [BITS_PER_WORD-1:0] cur_word;
  logic [BITS_PER_WORD-1:0] find_mask;
  logic [BITS_PER_WORD-1:0] cand;
  logic [SUM_W-1:0]         slot_ext;
  logic [SUM_W-1:0]         base_end;
  logic [SUM_W-1:0]         diff;
  logic [SUM_W-1:0]         found;
  logic [BIT_W-1:0]         offset;
  logic [BIT_W-1:0]         first;
  logic                     below;
  logic                     in_word;
  logic                     any;
  logic                     hit;
  logic                     last;
  logic                     bit_sel;
  logic                     searches;

  assign cur_word = bitmap[w];
  assign slot_ext = SUM_W'(slot_r);
  assign base_end = base + SUM_W'(BITS_PER_WORD);
  assign below    = slot_ext < base;
  assign in_word  = !below && (slot_ext < base_end);
  assign diff     = slot_ext - base;
  assign offset   = diff[BIT_W-1:0];
  assign bit_sel  = in_word && cur_word[offset];
  assign last     = (w == WIDX_W'(WORD_COUNT - 1));
  assign searches = (func_r == FUNC_ALLOC) || (func_r == FUNC_FIND);

  // find-next only looks at slots at or above the start slot
  always_comb begin
    if (below) begin
      find_mask = '1;
    end else if (in_word) begin
      find_mask = {BITS_PER_WORD{1'b1}} << offset;
    end else begin
      find_mask = '0;
    end
  end

  always_comb begin
    case (func_r)
      FUNC_ALLOC: cand = ~cur_word;
      FUNC_FIND:  cand = cur_word & find_mask;
      default:    cand = '0;
    endcase
  end

  assign any   = |cand;
  assign first = first_one(cand);
  assign found = base + SUM_W'(first);
  assign hit   = searches ? any : in_word;

  assign sts.done = hit || last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WORD_COUNT; i++) bitmap[i] <= '0;
      count <= '0;
      w     <= '0;
      base  <= '0;
    end else begin
      if (cmd.start) begin
        w    <= '0;
        base <= '0;
      end else if (cmd.step && !sts.done) begin
        w    <= w + 1'b1;
        base <= base_end;
      end

      if (cmd.step && sts.done) begin
        if ((func_r == FUNC_ALLOC) && hit) begin
          bitmap[w][first] <= 1'b1;
          if (count != COUNT_MAX) count <= count + 1'b1;
        end else if ((func_r == FUNC_FREE) && bit_sel) begin
          bitmap[w][offset] <= 1'b0;
          if (count != '0) count <= count - 1'b1;
        end
      end
    end
  end

  // request, result and output payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r <= func_t'(in_func);
      slot_r <= in_slot;
    end
    if (cmd.step && sts.done) begin
      res_status <= searches && !hit;
      res_index  <= (searches && hit) ? found[SLOT_W-1:0] : '0;
      res_set    <= (func_r == FUNC_TEST) && bit_sel;
    end
    if (cmd.publish) begin
      out_status <= res_status;
      out_index  <= res_index;
      out_set    <= res_set;
      out_count  <= count;
    end
  end

  `SBA_ASSERT_NOW(a_word_range, 1'b1, int'(w) < WORD_COUNT, "scan word index out of range")
  `SBA_ASSERT_NOW(a_count_bound, 1'b1, int'(count) <= TOTAL_SLOTS, "slot count above capacity")
  `SBA_ASSERT_NEXT(a_alloc_count,
    cmd.step && sts.done && (func_r == FUNC_ALLOC) && hit && (count != COUNT_MAX),
    count == $past(count) + 1'b1, "allocate did not raise the slot count")
  `SBA_ASSERT_NEXT(a_none_index, cmd.step && sts.done && !hit && searches,
    res_status && (res_index == '0), "failed search must report status with zero index")

endmodule

// ----- rtl/core/slot_bitmap_allocator.sv -----
// ---------------------------------------------------------------------------
// slot_bitmap_allocator: first-fit slot allocator over an occupancy bitmap
// flow: an accepted request walks the word scan, then waits in post for a free output register
// a new request is taken only after the previous result has been handed to the output register
// reset: synchronous rst clears the bitmap and the slot count, ready after reset
// ---------------------------------------------------------------------------
module slot_bitmap_allocator import sba_pkg::*; (
  input logic      clk,
  input logic      rst,
  sba_req_if.sink  req,
  sba_rsp_if.source rsp
);

  sba_cmd_t cmd;
  sba_sts_t sts;

  sba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sba_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (req.func),
    .in_slot    (req.slot_index),
    .out_status (rsp.status),
    .out_index  (rsp.result_index),
    .out_set    (rsp.slot_set),
    .out_count  (rsp.used_count)
  );

endmodule

// ----- test/slot_bitmap_allocator_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slot_bitmap_allocator_tb
// sends allocate, free, test and find-next requests with random idle cycles
// on both channels and checks every response, field by field, against an
// occupancy bitmap and slot count kept inside the testbench
// ---------------------------------------------------------------------------
module slot_bitmap_allocator_tb;
  import sba_pkg::*;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] result_index;
    logic              slot_set;
    logic [CNT_W-1:0]  used_count;
  } slot_reply_t;

  typedef enum int {
    TRAFFIC_FILL,
    TRAFFIC_DRAIN,
    TRAFFIC_MIX
  } traffic_t;

  class slot_table_checker;
    logic [BITS_PER_WORD-1:0] occupancy [WORD_COUNT];
    logic [CNT_W-1:0]         in_use;
    slot_reply_t              awaited [$];
    int                       errors;
    int                       requests_seen;

    function new();
      foreach (occupancy[w]) occupancy[w] = '0;
      in_use = '0;
      errors = 0;
      requests_seen = 0;
    endfunction

    function logic is_used(int s);
      if (s < 0 || s >= TOTAL_SLOTS) return 1'b0;
      return occupancy[s / BITS_PER_WORD][s % BITS_PER_WORD];
    endfunction

    function void mark(int s, logic v);
      occupancy[s / BITS_PER_WORD][s % BITS_PER_WORD] = v;
    endfunction

    // update the bitmap for one accepted request and queue its response
    function void note_request(func_t f, logic [SLOT_W-1:0] s);
      slot_reply_t r;
      r = '0;
      requests_seen++;
      case (f)
        FUNC_ALLOC: begin
          r.status = 1'b1;
          for (int i = 0; i < TOTAL_SLOTS; i++) begin
            if (!is_used(i)) begin
              mark(i, 1'b1);
              if (in_use != COUNT_MAX) in_use = in_use + 1'b1;
              r.status = 1'b0;
              r.result_index = SLOT_W'(i);
              break;
            end
          end
        end
        FUNC_FREE: begin
          // freeing a clear slot leaves the count alone
          if (is_used(int'(s))) begin
            mark(int'(s), 1'b0);
            if (in_use != '0) in_use = in_use - 1'b1;
          end
        end
        FUNC_TEST: begin
          r.slot_set = is_used(int'(s));
        end
        default: begin
          r.status = 1'b1;
          for (int i = int'(s); i < TOTAL_SLOTS; i++) begin
            if (is_used(i)) begin
              r.status = 1'b0;
              r.result_index = SLOT_W'(i);
              break;
            end
          end
        end
      endcase
      r.used_count = in_use;
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_reply(slot_reply_t got);
      slot_reply_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: response with no request outstanding, expected none actual %h",
                 $time, got);
        return;
      end
      want = awaited.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("result_index", want.result_index, got.result_index);
      compare_field("slot_set", want.slot_set, got.slot_set);
      compare_field("used_count", want.used_count, got.used_count);
    endfunction

    // some slot in use, searched from a random start; random slot if map is empty
    function logic [SLOT_W-1:0] pick_used();
      int start;
      start = $urandom_range(0, TOTAL_SLOTS - 1);
      for (int k = 0; k < TOTAL_SLOTS; k++) begin
        if (is_used((start + k) % TOTAL_SLOTS)) return SLOT_W'((start + k) % TOTAL_SLOTS);
      end
      return SLOT_W'(start);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  int   issued;

  sba_req_if req();
  sba_rsp_if rsp();

  slot_table_checker tracker = new();

  slot_bitmap_allocator dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("slot_bitmap_allocator_tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      tracker.check_reply('{rsp.status, rsp.result_index, rsp.slot_set, rsp.used_count});
    end
    if (!rst && req.valid && req.ready) begin
      tracker.note_request(func_t'(req.func), req.slot_index);
    end
  end

  // response side: random stalls plus one long hold-off so the request side backs up
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && tracker.requests_seen >= 200) begin
        hold_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= quiet || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  task automatic send_request(input func_t f, input logic [SLOT_W-1:0] s);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.func       <= f;
    req.slot_index <= s;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    issued++;
  endtask

  task automatic send_random(input traffic_t mode);
    int roll;
    int alloc_pct;
    int free_pct;
    int test_pct;
    roll = $urandom_range(0, 99);
    case (mode)
      TRAFFIC_FILL: begin
        alloc_pct = 85;
        free_pct  = 5;
        test_pct  = 5;
      end
      TRAFFIC_DRAIN: begin
        alloc_pct = 10;
        free_pct  = 70;
        test_pct  = 10;
      end
      default: begin
        alloc_pct = 25;
        free_pct  = 25;
        test_pct  = 25;
      end
    endcase
    if (roll < alloc_pct) begin
      send_request(FUNC_ALLOC, SLOT_W'($urandom));
    end else if (roll < alloc_pct + free_pct) begin
      send_request(FUNC_FREE, ($urandom_range(0, 3) != 0) ? tracker.pick_used()
                                                          : SLOT_W'($urandom));
    end else if (roll < alloc_pct + free_pct + test_pct) begin
      send_request(FUNC_TEST, $urandom_range(0, 1) ? tracker.pick_used()
                                                   : SLOT_W'($urandom));
    end else begin
      // start a little below a slot in use so the scan has to walk
      send_request(FUNC_FIND, $urandom_range(0, 1)
                   ? SLOT_W'(tracker.pick_used() - $urandom_range(0, 40))
                   : SLOT_W'($urandom));
    end
  endtask

  initial begin
    int       seg_left;
    traffic_t mode;
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.func       = FUNC_ALLOC;
    req.slot_index = '0;
    quiet          = 1'b0;
    issued         = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    send_request(FUNC_TEST, 8'd0);
    send_request(FUNC_FIND, 8'd0);
    send_request(FUNC_FIND, 8'd255);
    send_request(FUNC_FREE, 8'd0);
    send_request(FUNC_ALLOC, 8'd0);
    send_request(FUNC_ALLOC, 8'd255);
    send_request(FUNC_ALLOC, 8'd0);
    send_request(FUNC_TEST, 8'd1);
    send_request(FUNC_FREE, 8'd1);
    send_request(FUNC_TEST, 8'd1);
    send_request(FUNC_FREE, 8'd1);
    send_request(FUNC_FIND, 8'd1);
    send_request(FUNC_ALLOC, 8'd0);
    send_request(FUNC_FIND, 8'd3);
    send_request(FUNC_TEST, 8'd255);
    send_request(FUNC_FREE, 8'd255);
    send_request(FUNC_FIND, 8'hAA);
    send_request(FUNC_TEST, 8'h55);
    send_request(FUNC_ALLOC, 8'd0);
    send_request(FUNC_FIND, 8'd2);

    // fill the whole map, then keep allocating against a full map
    while (tracker.in_use != TOTAL_SLOTS) send_random(TRAFFIC_FILL);
    repeat (10) send_random(TRAFFIC_FILL);

    while (issued < 900) begin
      mode = traffic_t'($urandom_range(0, 2));
      seg_left = $urandom_range(30, 120);
      while (seg_left > 0 && issued < 900) begin
        quiet = (issued >= 450 && issued < 600);
        send_random(mode);
        seg_left--;
      end
    end
    quiet = 1'b0;
    req.valid <= 1'b0;

    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("slot_bitmap_allocator_tb passed");
    end else begin
      $display("slot_bitmap_allocator_tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sba_pkg.sv
rtl/core/sba_req_if.sv
rtl/core/sba_rsp_if.sv
rtl/core/sba_ctrl.sv
rtl/core/sba_datapath.sv
rtl/core/slot_bitmap_allocator.sv
test/slot_bitmap_allocator_tb.sv
